// File: rtl/core/maf_pkg.sv
`timescale 1ns / 1ps

package maf_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;
  localparam int USED_W   = 11;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_BAN_MODE = 1'b0;

  localparam logic [DATA_W-1:0] FREE_MARK = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] value;
  } rule_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    rule_t            wdata;
  } mem_req_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

// File: rtl/core/maf_if.sv
`timescale 1ns / 1ps

interface maf_in_if;
  import maf_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [DATA_W-1:0]   address;
  logic [DATA_W-1:0]   rule_mask;
  logic [DATA_W-1:0]   rule_value;

  modport source (output valid, op, address, rule_mask, rule_value, input ready);
  modport sink   (input valid, op, address, rule_mask, rule_value, output ready);
endinterface

interface maf_out_if;
  import maf_pkg::*;

  logic                valid;
  logic                ready;
  logic                reject;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [USED_W-1:0]   entries_used;

  modport source (output valid, reject, status, slot, entries_used, input ready);
  modport sink   (input valid, reject, status, slot, entries_used, output ready);
endinterface

// File: rtl/core/masked_address_filter_table_unit.sv
`timescale 1ns / 1ps

// Masked address filter table: a list of up to 1024 mask/value rules.
// Input channel in_ch carries an operation (lookup, add rule, remove rule)
// with an address and a rule; output channel out_ch returns one result per
// operation: verdict, status, slot and the count of slots in use.
// The APB port holds the ban_mode register (address 0, reset to 1).
// Each operation scans the used slots in order through a table memory with
// one read and one write port, one slot per cycle, with one shared comparator
// that stops at the first match. A result appears once a slot matches, or once
// all used slots have been compared without a match; an empty table or the
// unused operation code ends the scan without reading the table.
// A new operation is taken only once the previous one has finished its scan.
// A finished result sits in an output register, so the next operation can be
// taken while it waits; if the receiver still stalls when that next
// operation finishes, the scan holds until the result is transferred.
// Reset empties the list (slot count to zero) without a clearing pass, so
// the block is ready as soon as reset is released.
module masked_address_filter_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  maf_in_if.sink                        in_ch,
  maf_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [maf_pkg::PADDR_W-1:0]   paddr,
  input  logic [maf_pkg::PDATA_W-1:0]   pwdata,
  output logic [maf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import maf_pkg::*;

  logic     ban_mode_r, ban_mode_nxt;
  logic     reg_sel;
  mem_req_t mem_req;
  rule_t    rd_rule;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_BAN_MODE);

  always_comb begin
    ban_mode_nxt = ban_mode_r;
    if (psel && penable && pwrite && reg_sel) begin
      ban_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ban_mode_r <= 1'b1;
    end else begin
      ban_mode_r <= ban_mode_nxt;
    end
  end

  assign prdata = reg_sel ? {{(PDATA_W-1){1'b0}}, ban_mode_r} : '0;

  maf_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .ban_mode (ban_mode_r),
    .mem_req  (mem_req),
    .rd_rule  (rd_rule)
  );

  maf_table u_table (
    .clk     (clk),
    .req     (mem_req),
    .rd_rule (rd_rule)
  );

endmodule

// File: rtl/core/maf_table.sv
`timescale 1ns / 1ps

module maf_table (
  input  logic             clk,
  input  maf_pkg::mem_req_t req,
  output maf_pkg::rule_t    rd_rule
);
  import maf_pkg::*;

  rule_t mem [TABLE_DEPTH];
  rule_t rd_rule_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_rule_r <= mem[req.raddr];
    end
  end

  assign rd_rule = rd_rule_r;

endmodule

// File: rtl/core/maf_scan.sv
`timescale 1ns / 1ps

module maf_scan (
  input  logic              clk,
  input  logic              rst_n,
  maf_in_if.sink            in_ch,
  maf_out_if.source         out_ch,
  input  logic              ban_mode,
  output maf_pkg::mem_req_t mem_req,
  input  maf_pkg::rule_t    rd_rule
);
  import maf_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [OP_W-1:0]     op_r, op_nxt;
  logic [DATA_W-1:0]   addr_r, addr_nxt;
  logic [DATA_W-1:0]   msk_r, msk_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;

  logic                reject_r, reject_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [USED_W-1:0]   ent_r, ent_nxt;

  logic match, hit, more, finish, out_free;

  // The one comparator, shared by all three operations.
  always_comb begin
    case (op_r)
      OP_LOOKUP: match = (addr_r & rd_rule.mask) == rd_rule.value;
      OP_ADD:    match = rd_rule.value == FREE_MARK;
      OP_REMOVE: match = (rd_rule.mask == msk_r) && (rd_rule.value == val_r);
      default:   match = 1'b0;
    endcase
  end

  assign hit      = cmp_vld_r && match;
  assign more     = rd_idx_r < used_r;
  assign finish   = (state_r == S_SCAN) &&
                    ((op_r == OP_NONE) || hit || (!cmp_vld_r && !more));
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    msk_nxt       = msk_r;
    val_nxt       = val_r;
    reject_nxt    = reject_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    ent_nxt       = ent_r;

    mem_req.re          = 1'b0;
    mem_req.raddr       = rd_idx_r[IDX_W-1:0];
    mem_req.we          = 1'b0;
    mem_req.waddr       = cmp_idx_r;
    mem_req.wdata.mask  = msk_r;
    mem_req.wdata.value = val_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt      = in_ch.op;
          addr_nxt    = in_ch.address;
          msk_nxt     = in_ch.rule_mask;
          val_nxt     = in_ch.rule_value;
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (finish) begin
          // Everything holds while an earlier result still waits for its transfer.
          if (out_free) begin
            reject_nxt = 1'b0;
            status_nxt = ST_DONE;
            slot_nxt   = '0;
            case (op_r)
              OP_LOOKUP: begin
                reject_nxt = hit ? ban_mode : !ban_mode;
                if (hit) begin
                  slot_nxt = SLOT_W'(cmp_idx_r);
                end
              end
              OP_ADD: begin
                if (hit) begin
                  mem_req.we = 1'b1;
                  slot_nxt   = SLOT_W'(cmp_idx_r);
                end else if (used_r == CNT_W'(TABLE_DEPTH)) begin
                  status_nxt = ST_FULL;
                end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = used_r[IDX_W-1:0];
                  used_nxt      = used_r + 1'b1;
                  slot_nxt      = SLOT_W'(used_r);
                end
              end
              OP_REMOVE: begin
                if (hit) begin
                  mem_req.we          = 1'b1;
                  mem_req.wdata.mask  = rd_rule.mask;
                  mem_req.wdata.value = FREE_MARK;
                  slot_nxt            = SLOT_W'(cmp_idx_r);
                end else begin
                  status_nxt = ST_NOT_FOUND;
                end
              end
              default: begin
              end
            endcase
            ent_nxt       = USED_W'(used_nxt);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (more) begin
          // Read the next slot while the previous one is compared.
          mem_req.re  = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    op_r      <= op_nxt;
    addr_r    <= addr_nxt;
    msk_r     <= msk_nxt;
    val_r     <= val_nxt;
    reject_r  <= reject_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
    ent_r     <= ent_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.reject       = reject_r;
  assign out_ch.status       = status_r;
  assign out_ch.slot         = slot_r;
  assign out_ch.entries_used = ent_r;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import maf_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 1100;
  localparam logic [PADDR_W-1:0] BAN_ADDR = {REG_BAN_MODE, 2'b00};

  typedef struct packed {
    logic                reject;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [USED_W-1:0]   entries_used;
  } filter_result_t;

  // Rule table shadow, verdict prediction and the queue of verdicts still owed.
  class filter_scoreboard;
    logic [DATA_W-1:0] mask_tab [TABLE_DEPTH];
    logic [DATA_W-1:0] value_tab [TABLE_DEPTH];
    int unsigned       used;
    bit                ban;
    filter_result_t    verdict_q[$];
    int                errors, checked;
    int                lookups, hits, adds, full_reports, removes, misses;

    function new();
      used = 0;
      ban  = 1'b1;
    endfunction

    function void set_ban_mode(logic [PDATA_W-1:0] wdata);
      ban = wdata[0];
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void fault(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [DATA_W-1:0] addr,
                             logic [DATA_W-1:0] msk, logic [DATA_W-1:0] val);
      filter_result_t r;
      int             i;
      int             n;
      bit             hit;
      r   = '0;
      n   = used;
      hit = 1'b0;
      case (op)
        OP_LOOKUP: begin
          lookups++;
          for (i = 0; i < n; i++) begin
            if ((addr & mask_tab[i]) == value_tab[i]) begin
              hit    = 1'b1;
              r.slot = SLOT_W'(i);
              break;
            end
          end
          if (hit) hits++;
          r.reject = hit ? ban : !ban;
        end
        OP_ADD: begin
          adds++;
          i = 0;
          while (i < n && value_tab[i] != FREE_MARK) i++;
          if (i == n && n >= TABLE_DEPTH) begin
            r.status = ST_FULL;
            full_reports++;
          end else begin
            if (i == n) used = n + 1;
            mask_tab[i]  = msk;
            value_tab[i] = val;
            r.slot       = SLOT_W'(i);
          end
        end
        OP_REMOVE: begin
          removes++;
          r.status = ST_NOT_FOUND;
          for (i = 0; i < n; i++) begin
            if (mask_tab[i] == msk && value_tab[i] == val) begin
              value_tab[i] = FREE_MARK;
              r.status     = ST_DONE;
              r.slot       = SLOT_W'(i);
              break;
            end
          end
          if (r.status == ST_NOT_FOUND) misses++;
        end
        default: ;
      endcase
      r.entries_used = USED_W'(used);
      verdict_q.push_back(r);
    endfunction

    function void check_result(filter_result_t got);
      filter_result_t want;
      if (verdict_q.size() == 0) begin
        fault($sformatf("result with nothing outstanding: reject=%0b status=%0d slot=%0d used=%0d",
                        got.reject, got.status, got.slot, got.entries_used));
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      if (got.reject !== want.reject || got.status !== want.status ||
          got.slot !== want.slot || got.entries_used !== want.entries_used)
        fault({$sformatf("result %0d: expected reject=%0b status=%0d slot=%0d used=%0d",
                         checked, want.reject, want.status, want.slot, want.entries_used),
               $sformatf(", got reject=%0b status=%0d slot=%0d used=%0d",
                         got.reject, got.status, got.slot, got.entries_used)});
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  maf_in_if  in_ch ();
  maf_out_if out_ch ();

  filter_scoreboard sb;
  int               idle_pct;
  bit               hold_request;
  int               ban_writes;
  int               quiet_cycles;

  masked_address_filter_table_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one operation and returns at the edge of its transfer.
  task automatic send_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] addr,
                         logic [DATA_W-1:0] msk, logic [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.address    <= addr;
    in_ch.rule_mask  <= msk;
    in_ch.rule_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(op, addr, msk, val);
  endtask

  task automatic await_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [PDATA_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BAN_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_ban_mode(wdata);
    ban_writes++;
    @(posedge clk);
  endtask

  task automatic cfg_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= BAN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {{(PDATA_W-1){1'b0}}, sb.ban})
      sb.fault($sformatf("ban_mode read: expected %0d, got 0x%08h", sb.ban, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void make_rule(output logic [DATA_W-1:0] m, output logic [DATA_W-1:0] v);
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      m = '0;
      for (int k = 0; k < 4; k++)
        if ($urandom_range(0, 1) != 0) m[8*k +: 8] = 8'hFF;
    end else if (kind < 80) begin
      m = $urandom;
    end else if (kind < 95) begin
      m = '1;
    end else begin
      m = '0;
    end
    kind = $urandom_range(0, 99);
    if (kind < 80) v = $urandom & m;
    else if (kind < 90) v = $urandom;
    else v = FREE_MARK;
  endfunction

  // Random operations; lookups and removes are often aimed at rules that are in the table, with some noise.
  task automatic send_random();
    int                pick;
    int                idx;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] v;
    pick = $urandom_range(0, 99);
    idx  = (sb.used > 0) ? $urandom_range(0, sb.used - 1) : 0;
    if (pick < 40) begin
      if (sb.used > 0 && $urandom_range(0, 99) < 60)
        a = sb.value_tab[idx] | ($urandom & ~sb.mask_tab[idx]);
      else if ($urandom_range(0, 9) == 0)
        a = $urandom_range(0, 1) ? '1 : '0;
      else
        a = $urandom;
      send_op(OP_LOOKUP, a, $urandom, $urandom);
    end else if (pick < 70) begin
      make_rule(m, v);
      send_op(OP_ADD, $urandom, m, v);
    end else if (pick < 95) begin
      if (sb.used > 0 && $urandom_range(0, 99) < 70) begin
        m = sb.mask_tab[idx];
        v = sb.value_tab[idx];
      end else begin
        make_rule(m, v);
      end
      send_op(OP_REMOVE, $urandom, m, v);
    end else begin
      send_op(OP_NONE, $urandom, $urandom, $urandom);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    filter_result_t got;
    int             hold_left;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.reject       = out_ch.reject;
        got.status       = out_ch.status;
        got.slot         = out_ch.slot;
        got.entries_used = out_ch.entries_used;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (!rst_n || hold_left > 0) begin
        if (hold_left > 0) hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    sb               = new();
    idle_pct         = 27;
    hold_request     = 1'b0;
    ban_writes       = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_LOOKUP;
    in_ch.address    <= '0;
    in_ch.rule_mask  <= '0;
    in_ch.rule_value <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check();

    // Directed part with the reset ban mode.
    send_op(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_ADD,    32'h0000_0000, 32'hFFFF_FF00, 32'h0A00_0100);
    send_op(OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0001);
    send_op(OP_ADD,    32'h0000_0000, 32'hFFFF_0000, 32'hAC10_0000);
    send_op(OP_LOOKUP, 32'h0A00_01FF, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_LOOKUP, 32'hC0A8_0001, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_LOOKUP, 32'hC0A8_0002, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0001);
    // The freed slot keeps its all-ones mask, so the all-ones address hits it.
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0001);
    send_op(OP_ADD,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_LOOKUP, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
    // A rule whose value is all ones is itself a free slot.
    send_op(OP_ADD,    32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_FFFF);
    send_op(OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0102_0304);
    send_op(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_NONE,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_LOOKUP, 32'h0102_0304, 32'h0000_0000, 32'h0000_0000);
    await_idle();
    // Only bit 0 counts; the other bits are set to show they are dropped.
    cfg_write(32'hFFFF_FFFE);
    cfg_check();
    send_op(OP_LOOKUP, 32'h0A00_0155, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_LOOKUP, 32'h7F00_0001, 32'h0000_0000, 32'h0000_0000);

    repeat (200) send_random();
    await_idle();
    cfg_write(32'h0000_0001);
    cfg_check();
    idle_pct = 0;
    repeat (100) send_random();
    idle_pct     = 27;
    hold_request = 1'b1;
    repeat (100) send_random();
    await_idle();
    cfg_write(32'h0000_0000);
    cfg_check();
    repeat (150) send_random();
    await_idle();
    cfg_write(32'hFFFF_FFFF);
    cfg_check();

    // A few directed operations around the last used slot.
    send_op(OP_ADD, $urandom, 32'hFF00_0000, 32'h0B00_0000);
    send_op(OP_LOOKUP, $urandom, $urandom, $urandom);
    send_op(OP_REMOVE, $urandom, sb.mask_tab[sb.used-1], sb.value_tab[sb.used-1]);
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, $urandom, $urandom);
    send_op(OP_ADD, $urandom, 32'hFFFF_FFFF, 32'h0A0B_0C0D);
    send_op(OP_LOOKUP, 32'h0A0B_0C0D, $urandom, $urandom);
    send_op(OP_ADD, $urandom, 32'hFFFF_FFFF, 32'h0A0B_0C0E);
    send_op(OP_NONE, $urandom, $urandom, $urandom);
    await_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d lookups (%0d hits), %0d adds (%0d full), %0d removes (%0d misses).",
             sb.lookups, sb.hits, sb.adds, sb.full_reports, sb.removes, sb.misses);
    $display("Ban mode written %0d times; %0d results compared, %0d faults, %0d slots used.",
             ban_writes, sb.checked, sb.errors, sb.used);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/maf_pkg.sv
rtl/core/maf_if.sv
rtl/core/maf_table.sv
rtl/core/maf_scan.sv
rtl/core/masked_address_filter_table_unit.sv
tb/tb.sv
